// ----- rtl/lpmt_pkg.sv -----
`default_nettype none

package lpmt_pkg;

  localparam int unsigned TableEntriesDefault = 16;

  localparam logic [1:0] CmdAdd    = 2'd0;
  localparam logic [1:0] CmdLookup = 2'd1;
  localparam logic [1:0] CmdByIf   = 2'd2;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusNotFound = 2'd1;
  localparam logic [1:0] StatusFull     = 2'd2;

  localparam logic FamilyIpv4 = 1'b0;

  localparam int unsigned Ipv4Width = 32;
  localparam int unsigned Ipv6Width = 128;

  typedef struct packed {
    logic        family;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [7:0]  len;
    logic [15:0] iface;
  } entry_t;

  typedef struct packed {
    logic [1:0]  command;
    logic        family;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [15:0] iface;
  } query_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  index;
    logic [15:0] iface;
    logic [7:0]  len;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/lpmt_req_if.sv -----
`default_nettype none

interface lpmt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic        family;
  logic [63:0] address_high;
  logic [63:0] address_low;
  logic [7:0]  prefix_len;
  logic [15:0] interface_id;

  modport source (
    output valid, command, family, address_high, address_low, prefix_len, interface_id,
    input  ready
  );

  modport sink (
    input  valid, command, family, address_high, address_low, prefix_len, interface_id,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/lpmt_rsp_if.sv -----
`default_nettype none

interface lpmt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  entry_index;
  logic [15:0] found_interface;
  logic [7:0]  found_prefix_len;
  logic [63:0] result_address_high;
  logic [63:0] result_address_low;

  modport source (
    output valid, status, entry_index, found_interface, found_prefix_len,
           result_address_high, result_address_low,
    input  ready
  );

  modport sink (
    input  valid, status, entry_index, found_interface, found_prefix_len,
           result_address_high, result_address_low,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/lpmt_ram.sv -----
`default_nettype none

module lpmt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lpmt_match.sv -----
`default_nettype none

module lpmt_match (
  input  wire lpmt_pkg::query_t query_i,
  input  wire lpmt_pkg::entry_t entry_i,
  output logic                  hit_o
);
  import lpmt_pkg::*;

  logic [127:0] mask;
  logic [127:0] diff;

  always_comb begin
    if (entry_i.family == FamilyIpv4) begin
      if (entry_i.len > 8'(Ipv4Width)) begin
        mask = '0;
      end else begin
        mask = {96'b0, ~(32'hFFFF_FFFF >> entry_i.len)};
      end
    end else begin
      if (entry_i.len > 8'(Ipv6Width)) begin
        mask = '0;
      end else begin
        mask = ~({128{1'b1}} >> entry_i.len);
      end
    end
  end

  assign diff = {query_i.addr_high, query_i.addr_low} ^ {entry_i.addr_high, entry_i.addr_low};

  always_comb begin
    case (query_i.command)
      CmdLookup: hit_o = (entry_i.family == query_i.family) && ((diff & mask) == '0);
      CmdByIf:   hit_o = (entry_i.family == query_i.family) && (entry_i.iface == query_i.iface);
      default:   hit_o = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/local_prefix_match_table.sv -----
// Channel | Direction | Payload
// req     | in        | command, family, address_high/low, prefix_len, interface_id
// rsp     | out       | status, entry_index, found_interface, found_prefix_len, address
//
// An add or an unused command passes from acceptance through the hold register to the output register.
// A lookup or by-interface request reads the entry memory one entry per cycle, in order,
// through the single memory read port.
// Reset empties the table at once; entries need no clearing.
// A finished response waits in the output register while the next request is taken.
`default_nettype none

module local_prefix_match_table #(
  parameter int unsigned TableEntries = lpmt_pkg::TableEntriesDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lpmt_req_if.sink   req,
  lpmt_rsp_if.source rsp
);
  import lpmt_pkg::*;

  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW = $clog2(TableEntries + 1);
  localparam int unsigned EntryW = $bits(entry_t);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StResp
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] iss_q;
  logic            rd_vld_q;
  logic [IdxW-1:0] rd_idx_q;
  query_t          query_q;
  result_t         hold_q;
  result_t         out_q;
  logic            out_valid_q;

  query_t            req_query;
  entry_t            new_entry;
  entry_t            rd_entry;
  logic [EntryW-1:0] rd_data;
  logic              accept;
  logic              table_full;
  logic              ram_we;
  logic              ram_re;
  logic              hit;
  logic              out_free;
  logic [IdxW+3:0]   add_idx_ext;
  logic [IdxW+3:0]   scan_idx_ext;

  assign accept     = req.valid && req.ready;
  assign table_full = count_q >= CntW'(TableEntries);
  assign out_free   = !out_valid_q || rsp.ready;

  always_comb begin
    req_query.command   = req.command;
    req_query.family    = req.family;
    req_query.iface     = req.interface_id;
    if (req.family == FamilyIpv4) begin
      req_query.addr_high = '0;
      req_query.addr_low  = {32'b0, req.address_low[31:0]};
    end else begin
      req_query.addr_high = req.address_high;
      req_query.addr_low  = req.address_low;
    end
  end

  assign new_entry.family    = req_query.family;
  assign new_entry.addr_high = req_query.addr_high;
  assign new_entry.addr_low  = req_query.addr_low;
  assign new_entry.len       = req.prefix_len;
  assign new_entry.iface     = req.interface_id;

  assign ram_we = accept && (req.command == CmdAdd) && !table_full;
  assign ram_re = (state_q == StScan) && (iss_q < count_q);

  lpmt_ram #(
    .Width (EntryW),
    .Depth (TableEntries)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (new_entry),
    .re_i    (ram_re),
    .raddr_i (iss_q[IdxW-1:0]),
    .rdata_o (rd_data)
  );

  assign rd_entry = entry_t'(rd_data);

  lpmt_match u_match (
    .query_i (query_q),
    .entry_i (rd_entry),
    .hit_o   (hit)
  );

  assign add_idx_ext  = {4'b0, count_q[IdxW-1:0]};
  assign scan_idx_ext = {4'b0, rd_idx_q};

  assign req.ready = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      iss_q       <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      query_q     <= '0;
      hold_q      <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == StResp) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            query_q  <= req_query;
            iss_q    <= '0;
            rd_vld_q <= 1'b0;
            case (req.command)
              CmdAdd: begin
                if (table_full) begin
                  hold_q <= '{status: StatusFull, default: '0};
                end else begin
                  hold_q  <= '{status: StatusOk, index: add_idx_ext[3:0],
                               iface: new_entry.iface, len: new_entry.len,
                               addr_high: new_entry.addr_high,
                               addr_low: new_entry.addr_low};
                  count_q <= count_q + 1'b1;
                end
                state_q <= StResp;
              end
              CmdLookup, CmdByIf: begin
                state_q <= StScan;
              end
              default: begin
                hold_q  <= '{status: StatusNotFound, default: '0};
                state_q <= StResp;
              end
            endcase
          end
        end
        StScan: begin
          rd_vld_q <= ram_re;
          rd_idx_q <= iss_q[IdxW-1:0];
          if (ram_re) begin
            iss_q <= iss_q + 1'b1;
          end
          if (rd_vld_q && hit) begin
            hold_q  <= '{status: StatusOk, index: scan_idx_ext[3:0],
                         iface: rd_entry.iface, len: rd_entry.len,
                         addr_high: rd_entry.addr_high,
                         addr_low: rd_entry.addr_low};
            state_q <= StResp;
          end else if (!rd_vld_q && !ram_re) begin
            hold_q  <= '{status: StatusNotFound, default: '0};
            state_q <= StResp;
          end
        end
        StResp: begin
          if (out_free) begin
            out_q   <= hold_q;
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign rsp.valid               = out_valid_q;
  assign rsp.status              = out_q.status;
  assign rsp.entry_index         = out_q.index;
  assign rsp.found_interface     = out_q.iface;
  assign rsp.found_prefix_len    = out_q.len;
  assign rsp.result_address_high = out_q.addr_high;
  assign rsp.result_address_low  = out_q.addr_low;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TableEntries))
    else $error("entry count exceeds the table size");

  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> count_q == $past(count_q) + 1'b1)
    else $error("an accepted add did not advance the entry count");

  a_read_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> (state_q == StScan) && !ram_we)
    else $error("memory read outside a scan or overlapping a write");

  a_resp_from_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StResp) && out_free |=> out_valid_q && (state_q == StIdle))
    else $error("a finished request did not reach the output register");
`endif

endmodule

`default_nettype wire
